// File: rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache core: command codes,
// sequencer states, field widths and packed stream widths.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_BITS     = 32;
  localparam int VALUE_BITS   = 32;
  localparam int CMD_W        = 2;
  localparam int CFG_W        = 5;
  localparam int OCC_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_BITS  = CMD_W + KEY_BITS + VALUE_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + VALUE_BITS + OCC_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_EXISTS = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value store with least-recently-used replacement,
// walked one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time. A scan pass reads every slot's key and rank from
// block memories, a decide state follows, and a put or a get hit then runs a
// rank rewrite pass over all slots before the result is loaded. Rank 0 is the
// most recent entry; the valid ranks always form 0 to occupancy-1, so the
// eviction victim is the entry holding the top rank. Configuration
// (capacity_in_use, 0 acts as 1, above CAPACITY acts as CAPACITY) is always
// ready. It must be written only while the core is idle; the core itself
// does not enforce this.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // config write channel: capacity_in_use
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_data,
  // tdata: command [1:0], key [33:2], value [65:34], zero fill above
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [lkvc_pkg::IN_W-1:0]  s_axis_tdata,
  // tdata: found [0], read_value [32:1], occupancy [37:33], zero fill above
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [lkvc_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;
  localparam int KB    = lkvc_pkg::KEY_BITS;
  localparam int VB    = lkvc_pkg::VALUE_BITS;
  localparam int OW    = lkvc_pkg::OCC_W;
  localparam int KEY_LO = lkvc_pkg::CMD_W;
  localparam int VAL_LO = lkvc_pkg::CMD_W + KB;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  lkvc_pkg::state_t state, state_next;

  // configuration
  logic [lkvc_pkg::CFG_W-1:0] capacity_in_use;

  // captured transaction
  logic [lkvc_pkg::CMD_W-1:0] cmd;
  logic [KB-1:0]              key_q;
  logic [VB-1:0]              value_q;

  // storage
  logic [KB-1:0]    keys  [CAPACITY];
  logic [VB-1:0]    vals  [CAPACITY];
  logic [IDX_W-1:0] ranks [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    count;

  // read side of the memories
  logic [KB-1:0]    key_rd;
  logic [VB-1:0]    val_rd;
  logic [IDX_W-1:0] rank_rd;

  // slot walker
  logic [CNT_W-1:0] idx;
  logic             pipe_valid;
  logic [IDX_W-1:0] pipe_idx;

  // scan results
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic [IDX_W-1:0] old_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // update pass control
  logic             upd_promote;
  logic [IDX_W-1:0] ins_idx;
  logic             evict_pending;
  logic [IDX_W-1:0] victim_idx;

  // result register
  logic             res_found;
  logic [VB-1:0]    res_value;
  logic [OW-1:0]    res_occ;

  // sequencer outputs
  logic issue;
  logic scan_proc;
  logic upd_proc;
  logic last_proc;
  logic in_take;
  logic out_load;

  // decision terms
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] count_ext;
  logic [IDX_W-1:0] top_rank;
  logic             is_put;
  logic             is_get;
  logic             need_evict;
  logic             go_update;
  logic [IDX_W-1:0] ins_sel;
  logic [IDX_W-1:0] new_rank;
  logic [CNT_W-1:0] count_after;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= lkvc_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_in_use <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // decision terms
  // --------------------------------------------------------------------------
  always_comb begin
    cap_ext   = CMP_W'(capacity_in_use);
    count_ext = CMP_W'(count);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
    top_rank   = IDX_W'(count - 1'b1);
    is_put     = (cmd == lkvc_pkg::CMD_PUT);
    is_get     = (cmd == lkvc_pkg::CMD_GET);
    need_evict = (count_ext >= cap_eff) || (count_ext == CMP_W'(CAPACITY));
    go_update  = is_put || (is_get && hit);
    // reuse the lowest free slot, the victim's slot included
    if (need_evict && (!free_found || old_idx < free_idx)) begin
      ins_sel = old_idx;
    end else begin
      ins_sel = free_idx;
    end
    count_after = evict_pending ? count - 1'b1 : count;
  end

  // rank rewrite for the slot coming out of the memory
  always_comb begin
    if (upd_promote) begin
      if (pipe_idx == hit_idx) begin
        new_rank = '0;
      end else if (valid[pipe_idx] && rank_rd < hit_rank) begin
        new_rank = rank_rd + 1'b1;
      end else begin
        new_rank = rank_rd;
      end
    end else begin
      new_rank = (pipe_idx == ins_idx) ? '0 : rank_rd + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lkvc_pkg::ST_IDLE:   if (s_axis_tvalid) state_next = lkvc_pkg::ST_SCAN;
      lkvc_pkg::ST_SCAN:   if (last_proc) state_next = lkvc_pkg::ST_DECIDE;
      lkvc_pkg::ST_DECIDE: begin
        state_next = go_update ? lkvc_pkg::ST_UPDATE : lkvc_pkg::ST_RESULT;
      end
      lkvc_pkg::ST_UPDATE: if (last_proc) state_next = lkvc_pkg::ST_RESULT;
      lkvc_pkg::ST_RESULT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = lkvc_pkg::ST_IDLE;
      end
      default:             state_next = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    scan_proc     = 1'b0;
    upd_proc      = 1'b0;
    out_load      = 1'b0;
    case (state)
      lkvc_pkg::ST_IDLE: s_axis_tready = 1'b1;
      lkvc_pkg::ST_SCAN: begin
        issue     = (idx < CNT_W'(CAPACITY));
        scan_proc = pipe_valid;
      end
      lkvc_pkg::ST_UPDATE: begin
        issue    = (idx < CNT_W'(CAPACITY));
        upd_proc = pipe_valid;
      end
      lkvc_pkg::ST_RESULT: out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign last_proc = pipe_valid && (pipe_idx == LAST_IDX);

  // --------------------------------------------------------------------------
  // memories: registered reads, writes from the sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    key_rd  <= keys[idx[IDX_W-1:0]];
    rank_rd <= ranks[idx[IDX_W-1:0]];
    val_rd  <= vals[hit_idx];
    if (state == lkvc_pkg::ST_DECIDE && is_put) begin
      if (hit) begin
        vals[hit_idx] <= value_q;
      end else begin
        keys[ins_sel] <= key_q;
        vals[ins_sel] <= value_q;
      end
    end
    if (upd_proc) begin
      ranks[pipe_idx] <= new_rank;
    end
  end

  // --------------------------------------------------------------------------
  // walker and transaction capture
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= issue;
      if (in_take || state == lkvc_pkg::ST_DECIDE) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= idx[IDX_W-1:0];
    if (in_take) begin
      cmd     <= s_axis_tdata[lkvc_pkg::CMD_W-1:0];
      key_q   <= s_axis_tdata[KEY_LO +: KB];
      value_q <= s_axis_tdata[VAL_LO +: VB];
    end
  end

  // scan: first matching key, holder of the top rank, lowest free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (in_take) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (scan_proc) begin
      if (valid[pipe_idx] && key_rd == key_q && !hit) begin
        hit <= 1'b1;
      end
      if (!valid[pipe_idx] && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_proc) begin
      if (valid[pipe_idx] && key_rd == key_q && !hit) begin
        hit_idx  <= pipe_idx;
        hit_rank <= rank_rd;
      end
      if (valid[pipe_idx] && rank_rd == top_rank) begin
        old_idx <= pipe_idx;
      end
      if (!valid[pipe_idx] && !free_found) begin
        free_idx <= pipe_idx;
      end
    end
    if (state == lkvc_pkg::ST_DECIDE) begin
      upd_promote <= hit;
      ins_idx     <= ins_sel;
    end
    // after a promote the victim is whoever still holds the top rank
    if (upd_proc && valid[pipe_idx] && pipe_idx != hit_idx && new_rank == top_rank) begin
      victim_idx <= pipe_idx;
    end
  end

  // --------------------------------------------------------------------------
  // valid bits and entry count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      count         <= '0;
      evict_pending <= 1'b0;
    end else begin
      if (state == lkvc_pkg::ST_DECIDE) begin
        evict_pending <= is_put && hit && (count_ext > cap_eff);
        if (is_put && !hit) begin
          if (need_evict) begin
            // drop the victim and claim the insert slot in one update
            valid <= (valid & ~(CAPACITY'(1) << old_idx)) | (CAPACITY'(1) << ins_sel);
          end else begin
            valid[ins_sel] <= 1'b1;
            count          <= count + 1'b1;
          end
        end
      end
      if (out_load) begin
        evict_pending <= 1'b0;
        if (evict_pending) begin
          valid[victim_idx] <= 1'b0;
          count             <= count_after;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_found <= hit;
      res_value <= (is_get && hit) ? val_rd : '0;
      res_occ   <= OW'(count_after);
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0]            = res_found;
    m_axis_tdata[1 +: VB]      = res_value;
    m_axis_tdata[1 + VB +: OW] = res_occ;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid)) == count)
    else $error("entry count differs from the number of valid slots");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while a transaction is in flight");

  a_victim_valid: assert property (@(posedge clk) disable iff (rst)
    state == lkvc_pkg::ST_DECIDE && is_put && !hit && need_evict |-> valid[old_idx])
    else $error("eviction victim of a put miss is not a valid slot");

endmodule

// File: tb/tb_lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// Self-checking bench for the LRU key-value cache core. A directed table
// covers the empty cache, extreme keys and values, overwrite, the unused
// command, capacity clamping and eviction. Random phases follow under several
// capacity settings. Typed rows are checked against the results in the
// table, all other results against a behavioral LRU model kept in the bench.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;

  localparam int CMD_W      = lkvc_pkg::CMD_W;
  localparam int KEY_BITS   = lkvc_pkg::KEY_BITS;
  localparam int VALUE_BITS = lkvc_pkg::VALUE_BITS;
  localparam int OCC_W      = lkvc_pkg::OCC_W;
  localparam int CFG_W      = lkvc_pkg::CFG_W;
  localparam int IN_BITS    = lkvc_pkg::IN_BITS;
  localparam int IN_W       = lkvc_pkg::IN_W;
  localparam int OUT_W      = lkvc_pkg::OUT_W;

  localparam int DEPTH = lkvc_pkg::CAPACITY_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL_SIZE = 48;
  localparam int STEADY_PHASE = 5;
  localparam int PAUSE_PHASE = 2;
  localparam logic [5:0] CAP_RANDOM = 6'h3f;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic [OCC_W-1:0]      occupancy;
  } cache_result_t;

  typedef enum logic {ROW_ACCESS, ROW_CAPACITY} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CMD_W-1:0]      cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [CFG_W-1:0]      capacity;
    logic                  typed;
    cache_result_t         result;
  } access_row_t;

  localparam int DIRECTED_ROWS = 23;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // bench copy of the cache state
  logic [KEY_BITS-1:0]   slot_key [DEPTH];
  logic [VALUE_BITS-1:0] slot_value [DEPTH];
  bit                    slot_live [DEPTH];
  int unsigned           slot_age [DEPTH];
  int unsigned           live_count;
  logic [CFG_W-1:0]      capacity_reg;

  cache_result_t pending_results[$];
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

  bit steady = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int put_count = 0;
  int get_count = 0;
  int query_count = 0;
  int get_hits = 0;
  int evictions = 0;
  int capacity_writes = 0;

  access_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty cache
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd0}},
    '{ROW_ACCESS, lkvc_pkg::CMD_EXISTS, 32'hffff_ffff, 32'hffff_ffff, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd0}},
    '{ROW_ACCESS, lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd1}},
    '{ROW_ACCESS, lkvc_pkg::CMD_PUT, 32'hffff_ffff, 32'hffff_ffff, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd2}},
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'hffff_ffff, 5'd2}},
    '{ROW_ACCESS, CMD_UNUSED, 32'h0000_0000, 32'h1234_5678, 5'd0, 1'b1,
      '{1'b1, 32'h0, 5'd2}},
    // overwrite an existing key
    '{ROW_ACCESS, lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'ha5a5_a5a5, 5'd0, 1'b1,
      '{1'b1, 32'h0, 5'd2}},
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'ha5a5_a5a5, 5'd2}},
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd2}},
    // zero capacity acts as one; queries never evict
    '{ROW_CAPACITY, lkvc_pkg::CMD_PUT, 32'h0, 32'h0, 5'd0, 1'b0,
      '{1'b0, 32'h0, 5'd0}},
    '{ROW_ACCESS, lkvc_pkg::CMD_EXISTS, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'h0, 5'd2}},
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'hffff_ffff, 5'd2}},
    // a put on a hit drops one entry, a new key replaces the last one
    '{ROW_ACCESS, lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h5a5a_5a5a, 5'd0, 1'b1,
      '{1'b1, 32'h0, 5'd1}},
    '{ROW_ACCESS, lkvc_pkg::CMD_PUT, 32'h0000_0007, 32'h0000_0001, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd1}},
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd1}},
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'h0000_0007, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'h0000_0001, 5'd1}},
    // oversized capacity clamps to the slot count
    '{ROW_CAPACITY, lkvc_pkg::CMD_PUT, 32'h0, 32'h0, 5'd31, 1'b0,
      '{1'b0, 32'h0, 5'd0}},
    '{ROW_ACCESS, lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7fff_ffff, 5'd0, 1'b1,
      '{1'b0, 32'h0, 5'd2}},
    '{ROW_ACCESS, lkvc_pkg::CMD_EXISTS, 32'h0000_0007, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'h0, 5'd2}},
    '{ROW_ACCESS, CMD_UNUSED, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'h0, 5'd2}},
    '{ROW_CAPACITY, lkvc_pkg::CMD_PUT, 32'h0, 32'h0, 5'd16, 1'b0,
      '{1'b0, 32'h0, 5'd0}},
    '{ROW_ACCESS, lkvc_pkg::CMD_PUT, 32'h1234_5678, 32'hdead_beef, 5'd0, 1'b0,
      '{1'b0, 32'h0, 5'd0}},
    '{ROW_ACCESS, lkvc_pkg::CMD_GET, 32'h1234_5678, 32'h0000_0000, 5'd0, 1'b0,
      '{1'b0, 32'h0, 5'd0}}
  };

  lru_key_value_cache_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- LRU model
  function automatic void make_most_recent(input int slot);
    int unsigned age;
    age = slot_age[slot];
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_live[i] && i != slot && slot_age[i] < age) slot_age[i]++;
    end
    slot_age[slot] = 0;
  endfunction

  function automatic void drop_least_recent();
    int victim;
    int unsigned oldest;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_live[i] && (victim < 0 || slot_age[i] >= oldest)) begin
        victim = i;
        oldest = slot_age[i];
      end
    end
    if (victim >= 0) begin
      slot_live[victim] = 1'b0;
      if (live_count > 0) live_count--;
      evictions++;
    end
  endfunction

  function automatic cache_result_t predict_access(input logic [CMD_W-1:0] cmd,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [VALUE_BITS-1:0] value);
    cache_result_t res;
    int unsigned limit;
    int hit_slot;
    int free_slot;
    limit = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
    hit_slot = -1;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_key[i] == key) hit_slot = i;
    end
    res.found = (hit_slot >= 0);
    res.read_value = '0;
    if (cmd == lkvc_pkg::CMD_PUT) begin
      if (hit_slot >= 0) begin
        slot_value[hit_slot] = value;
        make_most_recent(hit_slot);
        if (live_count > limit) drop_least_recent();
      end else begin
        if (live_count + 1 > limit || live_count >= DEPTH) drop_least_recent();
        free_slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (!slot_live[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (slot_live[i]) slot_age[i]++;
          end
          slot_key[free_slot] = key;
          slot_value[free_slot] = value;
          slot_live[free_slot] = 1'b1;
          slot_age[free_slot] = 0;
          live_count++;
        end
      end
    end else if (cmd == lkvc_pkg::CMD_GET && hit_slot >= 0) begin
      res.read_value = slot_value[hit_slot];
      make_most_recent(hit_slot);
    end
    res.occupancy = live_count[OCC_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [KEY_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] value, input logic typed,
                             input cache_result_t typed_result);
    cache_result_t want;
    while (!steady && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, value, key, cmd};
    do @(posedge clk); while (!s_axis_tready);
    want = predict_access(cmd, key, value);
    if (typed) want = typed_result;
    pending_results.push_back(want);
    items_sent++;
    case (cmd)
      lkvc_pkg::CMD_PUT: put_count++;
      lkvc_pkg::CMD_GET: begin
        get_count++;
        if (want.found) get_hits++;
      end
      default: query_count++;
    endcase
  endtask

  // hold the sender until every outstanding result has drained
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] capacity);
    cfg_valid <= 1'b1;
    cfg_data  <= capacity;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_reg = capacity;
    capacity_writes++;
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found      = m_axis_tdata[0];
      got.read_value = m_axis_tdata[VALUE_BITS:1];
      got.occupancy  = m_axis_tdata[VALUE_BITS+OCC_W:VALUE_BITS+1];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: found=%0b read_value=%h occupancy=%0d",
                   $realtime, got.found, got.read_value, got.occupancy);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.read_value !== want.read_value ||
            got.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] mismatch: expected found=%0b read_value=%h occupancy=%0d",
                     $realtime, want.found, want.read_value, want.occupancy);
            $display("          got      found=%0b read_value=%h occupancy=%0d",
                     got.found, got.read_value, got.occupancy);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("lru_key_value_cache_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    logic [5:0] phase_caps [RANDOM_PHASES];
    logic [CMD_W-1:0] cmd;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_BITS-1:0] value;
    int pool_limit;
    int pick;
    cache_result_t none;

    phase_caps = '{6'd16, 6'd1, 6'd31, 6'd0, 6'd2, 6'd16, CAP_RANDOM, CAP_RANDOM, 6'd8, 6'd16};
    none = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_live[i] = 1'b0;
      slot_age[i] = 0;
    end
    live_count = 0;
    capacity_reg = lkvc_pkg::CFG_RESET;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CAPACITY) begin
        drain_results();
        write_capacity(directed_rows[r].capacity);
      end else begin
        send_access(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].value,
                    directed_rows[r].typed, directed_rows[r].result);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      steady = (p == STEADY_PHASE);
      write_capacity((phase_caps[p] == CAP_RANDOM) ? CFG_W'($urandom_range(0, 31))
                                                   : phase_caps[p][CFG_W-1:0]);
      // small pools favor hits, large ones keep the cache full and evicting
      pool_limit = $urandom_range(4, POOL_SIZE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(0, 99);
        cmd = (pick < 45) ? lkvc_pkg::CMD_PUT :
              (pick < 80) ? lkvc_pkg::CMD_GET :
              (pick < 95) ? lkvc_pkg::CMD_EXISTS : CMD_UNUSED;
        key = ($urandom_range(0, 9) == 0) ? $urandom
                                          : key_pool[$urandom_range(0, pool_limit - 1)];
        pick = $urandom_range(0, 15);
        value = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
        send_access(cmd, key, value, 1'b0, none);
      end
    end

    drain_results();
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d accesses: %0d puts, %0d gets (%0d hits), %0d queries",
             items_sent, put_count, get_count, get_hits, query_count);
    $display("%0d evictions over %0d capacity settings, %0d mismatches",
             evictions, capacity_writes, mismatches);
    if (mismatches == 0) begin
      $display("lru_key_value_cache_core regression: pass");
    end else begin
      $display("lru_key_value_cache_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache_core.sv
tb/tb_lru_key_value_cache_core.sv
